FILE: rtl/imu_cal_pkg.sv
// Shared types and constants for the IMU calibration accumulator
package imu_cal_pkg;

    localparam int ROT_COS = 31637;
    localparam int ROT_SIN = 8536;

    typedef enum logic [1:0] {
        CMD_STATIC   = 2'd0,
        CMD_ROTATION = 2'd1,
        CMD_FINISH   = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_NO_STATIC = 2'd1,
        ERR_NO_ROT    = 2'd2,
        ERR_ZERO_RATE = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DEBIAS,
        S_RATIO_START,
        S_RATIO_WAIT,
        S_CLEAR,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic [3:0] div_sel;
        logic       div_store;
        logic       debias;
        logic       clear;
        logic       out_load;
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic       div_done;
        logic       static_zero;
        logic       rot_zero;
        logic       rate_zero;
    } t_stat;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    // rounding helper: floor((p + 2^14) / 2^15), then saturate
    function automatic logic signed [15:0] round_q15(input logic signed [35:0] p);
        logic signed [35:0] t;
        t = p + 36'sd16384;
        return sat16(64'(t >>> 15));
    endfunction

endpackage

FILE: rtl/imu_bias_calibration_accumulator.sv
// Top level of the IMU bias and cross-axis calibration accumulator
//
// Input channel: i_valid / o_stall with cmd and six raw IMU fields.
// Static (cmd 0) and rotation (cmd 1) requests are rotated into the body frame
// and summed until their count saturates; the block takes one such request per
// cycle while o_stall is low. Cmd 3 is taken and dropped.
// A finish request (cmd 2) runs nine mean divisions and two ratio divisions on
// one shared bit-serial divider of COUNT_BITS+17 steps each (33 below
// COUNT_BITS 16), plus set-up and hand-over per division; an error ends the
// run early. The result then shows on o_valid / i_stall.
// The sums and counts are cleared as the result is loaded.
// o_stall is high from the finish request until its result is taken. A stalled
// result holds its fields until taken. Gravity must be written via i_cfg_we /
// i_cfg_data only while the block is idle; the block itself does not enforce
// it. Reset clears sums, counts and state and sets gravity to 20091.
module imu_bias_calibration_accumulator
    import imu_cal_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_accel_bias_x,
    output logic signed [15:0] o_accel_bias_y,
    output logic signed [15:0] o_accel_bias_z,
    output logic signed [15:0] o_gyro_bias_x,
    output logic signed [15:0] o_gyro_bias_y,
    output logic signed [15:0] o_gyro_bias_z,
    output logic signed [15:0] o_z_to_x_ratio,
    output logic signed [15:0] o_z_to_y_ratio,
    output logic [1:0]         o_error_code
);
    t_ctrl              ctrl;
    t_stat              stat;
    logic signed [15:0] res [8];

    imu_cal_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_cmd_finish (i_cmd == CMD_FINISH),
        .i_out_stall  (i_stall),
        .i_stat       (stat),
        .o_ctrl       (ctrl),
        .o_stall      (o_stall),
        .o_valid      (o_valid)
    );

    imu_cal_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cmd        (i_cmd),
        .i_gyro_x     (i_gyro_x),
        .i_gyro_y     (i_gyro_y),
        .i_gyro_z     (i_gyro_z),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (stat),
        .o_res        (res),
        .o_error_code (o_error_code)
    );

    assign o_accel_bias_x = res[0];
    assign o_accel_bias_y = res[1];
    assign o_accel_bias_z = res[2];
    assign o_gyro_bias_x  = res[3];
    assign o_gyro_bias_y  = res[4];
    assign o_gyro_bias_z  = res[5];
    assign o_z_to_x_ratio = res[6];
    assign o_z_to_y_ratio = res[7];
endmodule

FILE: rtl/imu_cal_div.sv
// Sequential signed divider, rounding to nearest with ties away from zero
module imu_cal_div
    import imu_cal_pkg::*;
#(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [DEN_BITS-1:0] i_den,
    output logic                       o_done,
    output logic signed [NUM_BITS:0]   o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 2);

    logic                r_busy, n_busy;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [NUM_BITS:0]   r_n, n_n;
    logic [DEN_BITS:0]   r_d, n_d;
    logic [DEN_BITS+1:0] r_rem, n_rem;
    logic [NUM_BITS:0]   r_q, n_q;
    logic                r_neg, n_neg;
    logic                r_done, n_done;
    logic [DEN_BITS+1:0] trial;
    logic [NUM_BITS:0]   abs_n;
    logic [DEN_BITS:0]   abs_d;

    always_comb begin
        abs_n = i_num[NUM_BITS-1] ? (NUM_BITS+1)'(-i_num) : (NUM_BITS+1)'(i_num);
        abs_d = i_den[DEN_BITS-1] ? (DEN_BITS+1)'(-i_den) : (DEN_BITS+1)'(i_den);
        trial = {r_rem[DEN_BITS:0], r_n[NUM_BITS]};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_n    = r_n;
        n_d    = r_d;
        n_rem  = r_rem;
        n_q    = r_q;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(NUM_BITS + 1);
            // add half the divisor up front
            n_n    = abs_n + (NUM_BITS+1)'(abs_d >> 1);
            n_d    = abs_d;
            n_rem  = '0;
            n_q    = '0;
            n_neg  = i_num[NUM_BITS-1] ^ i_den[DEN_BITS-1];
        end else if (r_busy) begin
            n_n = {r_n[NUM_BITS-1:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                n_rem = trial - {1'b0, r_d};
                n_q   = {r_q[NUM_BITS-1:0], 1'b1};
            end else begin
                n_rem = trial;
                n_q   = {r_q[NUM_BITS-1:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_n   <= n_n;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

FILE: rtl/imu_cal_ctrl.sv
// Controller state machine for the IMU calibration accumulator
module imu_cal_ctrl
    import imu_cal_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_cmd_finish,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_stall,
    output logic  o_valid
);
    t_state     r_state, n_state;
    logic [3:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_cmd_finish) begin
                    n_state = i_stat.static_zero ? S_CLEAR : S_DIV_START;
                    n_sel   = '0;
                end
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_sel == 4'd5 && i_stat.rot_zero) begin
                        n_state = S_CLEAR;
                    end else if (r_sel == 4'd8) begin
                        n_state = S_DEBIAS;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DEBIAS: begin
                n_sel   = 4'd9;
                n_state = S_RATIO_START;
            end
            S_RATIO_START: n_state = i_stat.rate_zero ? S_CLEAR : S_RATIO_WAIT;
            S_RATIO_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_sel == 4'd10) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_RATIO_START;
                    end
                end
            end
            S_CLEAR: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.div_sel   = r_sel;
        o_ctrl.accept    = (r_state == S_IDLE) && i_valid;
        o_ctrl.div_start = (r_state == S_DIV_START) ||
                           ((r_state == S_RATIO_START) && !i_stat.rate_zero);
        o_ctrl.div_store = ((r_state == S_DIV_WAIT) || (r_state == S_RATIO_WAIT))
                           && i_stat.div_done;
        o_ctrl.debias    = (r_state == S_DEBIAS);
        o_ctrl.clear     = (r_state == S_CLEAR);
        o_ctrl.out_load  = (r_state == S_CLEAR);
        o_stall          = (r_state != S_IDLE);
        o_valid          = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

`ifndef SYNTHESIS
    a_out_from_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && !$past(r_state == S_OUT) |-> $past(r_state == S_CLEAR))
        else $error("result shown without clearing pass");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && i_out_stall |=> (r_state == S_OUT))
        else $error("stalled result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.accept |-> (r_state == S_IDLE))
        else $error("request taken while busy");
`endif
endmodule

FILE: rtl/imu_cal_dp.sv
// Datapath: rotation, accumulators, mean and ratio division, result register
module imu_cal_dp
    import imu_cal_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data,
    output t_stat              o_stat,
    output logic signed [15:0] o_res [8],
    output logic [1:0]         o_error_code
);
    localparam int SUM_BITS = COUNT_BITS + 16;
    localparam int NUM_BITS = (SUM_BITS > 32) ? SUM_BITS : 32;
    localparam int DEN_BITS = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [14:0]                r_gravity;
    logic [COUNT_BITS-1:0]      r_scount, r_rcount;
    logic signed [SUM_BITS-1:0] r_ssum [6];
    logic signed [SUM_BITS-1:0] r_rsum [3];
    logic signed [15:0]         r_mean [11];
    logic signed [16:0]         r_dev [3];
    logic signed [15:0]         r_res [8];
    logic [1:0]                 r_err;

    logic signed [15:0] rg [3];
    logic signed [15:0] ra [3];
    logic signed [NUM_BITS-1:0] div_num;
    logic signed [DEN_BITS-1:0] div_den;
    logic signed [NUM_BITS:0]   div_q;
    logic                       div_done;
    t_cmd                       cmd;

    function automatic void rot(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z,
                                output logic signed [15:0] r0,
                                output logic signed [15:0] r1,
                                output logic signed [15:0] r2);
        logic signed [35:0] zn;
        logic signed [35:0] xe;
        zn = -36'(z);
        xe = 36'(x);
        r0 = round_q15(xe * 36'sd31637 - zn * 36'sd8536);
        r1 = sat16(-64'(y));
        r2 = round_q15(xe * 36'sd8536 + zn * 36'sd31637);
    endfunction

    always_comb begin
        rot(i_gyro_x, i_gyro_y, i_gyro_z, rg[0], rg[1], rg[2]);
        rot(i_accel_x, i_accel_y, i_accel_z, ra[0], ra[1], ra[2]);
        cmd = t_cmd'(i_cmd);
    end

    always_comb begin
        div_num = '0;
        div_den = DEN_BITS'(1);
        if (i_ctrl.div_sel < 4'd6) begin
            div_num = NUM_BITS'(r_ssum[i_ctrl.div_sel[2:0]]);
            div_den = DEN_BITS'($signed({1'b0, r_scount}));
        end else if (i_ctrl.div_sel < 4'd9) begin
            div_num = NUM_BITS'(r_rsum[2'(i_ctrl.div_sel - 4'd6)]);
            div_den = DEN_BITS'($signed({1'b0, r_rcount}));
        end else begin
            div_num = NUM_BITS'(-(32'(r_dev[i_ctrl.div_sel[0] ? 0 : 1]) <<< 14));
            div_den = DEN_BITS'(r_dev[2]);
        end
    end

    imu_cal_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= 15'd20091;
            r_scount  <= '0;
            r_rcount  <= '0;
            for (int i = 0; i < 6; i++) r_ssum[i] <= '0;
            for (int i = 0; i < 3; i++) r_rsum[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gravity <= i_cfg_data;
            end
            if (i_ctrl.clear) begin
                r_scount <= '0;
                r_rcount <= '0;
                for (int i = 0; i < 6; i++) r_ssum[i] <= '0;
                for (int i = 0; i < 3; i++) r_rsum[i] <= '0;
            end else if (i_ctrl.accept && cmd == CMD_STATIC && r_scount != COUNT_MAX) begin
                r_scount <= r_scount + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_ssum[i]     <= r_ssum[i] + SUM_BITS'(ra[i]);
                    r_ssum[3 + i] <= r_ssum[3 + i] + SUM_BITS'(rg[i]);
                end
            end else if (i_ctrl.accept && cmd == CMD_ROTATION &&
                         r_rcount != COUNT_MAX) begin
                r_rcount <= r_rcount + 1'b1;
                for (int i = 0; i < 3; i++) r_rsum[i] <= r_rsum[i] + SUM_BITS'(rg[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && cmd == CMD_FINISH) begin
            for (int i = 0; i < 11; i++) r_mean[i] <= '0;
        end
        if (i_ctrl.div_store) begin
            r_mean[i_ctrl.div_sel] <= sat16(64'(div_q));
        end
        if (i_ctrl.debias) begin
            for (int i = 0; i < 3; i++) begin
                r_dev[i] <= 17'(r_mean[6 + i]) - 17'(r_mean[3 + i]);
            end
        end
        if (i_ctrl.out_load) begin
            for (int i = 0; i < 6; i++) r_res[i] <= r_mean[i];
            r_res[2] <= sat16(64'(r_mean[2]) - 64'(r_gravity));
            r_res[6] <= r_mean[9];
            r_res[7] <= r_mean[10];
            if (r_scount == '0) begin
                r_err <= ERR_NO_STATIC;
                for (int i = 0; i < 8; i++) r_res[i] <= '0;
            end else if (r_rcount == '0) begin
                r_err <= ERR_NO_ROT;
            end else if (r_dev[2] == '0) begin
                r_err <= ERR_ZERO_RATE;
            end else begin
                r_err <= ERR_OK;
            end
        end
    end

    assign o_stat.div_done    = div_done;
    assign o_stat.static_zero = (r_scount == '0);
    assign o_stat.rot_zero    = (r_rcount == '0);
    assign o_stat.rate_zero   = (r_dev[2] == '0);
    assign o_res              = r_res;
    assign o_error_code       = r_err;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_scount == '0) && (r_rcount == '0))
        else $error("counts not cleared after finish");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.div_start |=> !div_done)
        else $error("divider done too early");
    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scount == COUNT_MAX) && !i_ctrl.clear |=> (r_scount == COUNT_MAX))
        else $error("static count wrapped");
`endif
endmodule
